>>> rtl/pcpd_pkg.sv
// shared types, register indexes and saturation helpers for the pid core
package pcpd_pkg;

    localparam int DATA_W = 32;
    localparam int LIM_W  = 31;
    localparam int SUM_W  = 35;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_GAIN_P    = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_GAIN_I    = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_GAIN_D    = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_OUT_LIM   = 3'd4;
    localparam logic [ADDR_W-1:0] CFG_INT_LIM   = 3'd5;
    localparam logic [ADDR_W-1:0] CFG_DEAD_ZONE = 3'd6;
    localparam logic [ADDR_W-1:0] CFG_SEP_THR   = 3'd7;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    localparam logic [LIM_W-1:0] LIM_RESET = {LIM_W{1'b1}};

    typedef struct packed {
        logic signed [DATA_W-1:0] measured;
        logic signed [DATA_W-1:0] target;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     in_dead_zone;
    } out_t;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic [LIM_W-1:0]         output_limit;
        logic [LIM_W-1:0]         integral_limit;
        logic [LIM_W-1:0]         dead_zone;
        logic [LIM_W-1:0]         separation_threshold;
    } cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] prev_error;
        logic signed [DATA_W-1:0] prev_prev_error;
        logic signed [DATA_W-1:0] integral_sum;
        logic signed [DATA_W-1:0] last_incremental_output;
    } state_t;

    function automatic logic signed [SUM_W-1:0] ext32(input logic signed [DATA_W-1:0] v);
        ext32 = {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] max_w;
        logic signed [SUM_W-1:0] min_w;
        max_w = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        min_w = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (v > max_w) begin
            sat32 = max_w[DATA_W-1:0];
        end else if (v < min_w) begin
            sat32 = min_w[DATA_W-1:0];
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [SUM_W-1:0] v,
                                                           input logic [LIM_W-1:0] lim);
        logic signed [SUM_W-1:0] pos_w;
        logic signed [SUM_W-1:0] neg_w;
        pos_w = {{(SUM_W-LIM_W){1'b0}}, lim};
        neg_w = -pos_w;
        if (v > pos_w) begin
            clamp_sym = pos_w[DATA_W-1:0];
        end else if (v < neg_w) begin
            clamp_sym = neg_w[DATA_W-1:0];
        end else begin
            clamp_sym = v[DATA_W-1:0];
        end
    endfunction

endpackage

>>> rtl/pcpd_cfg.sv
// configuration register bank written through the plain write port
module pcpd_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [pcpd_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [pcpd_pkg::DATA_W-1:0] cfg_wdata,
    output pcpd_pkg::cfg_t              cfg
);
    import pcpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MODE:      cfg_next.mode                 = cfg_wdata[0];
                CFG_GAIN_P:    cfg_next.gain_p               = cfg_wdata;
                CFG_GAIN_I:    cfg_next.gain_i               = cfg_wdata;
                CFG_GAIN_D:    cfg_next.gain_d               = cfg_wdata;
                CFG_OUT_LIM:   cfg_next.output_limit         = cfg_wdata[LIM_W-1:0];
                CFG_INT_LIM:   cfg_next.integral_limit       = cfg_wdata[LIM_W-1:0];
                CFG_DEAD_ZONE: cfg_next.dead_zone            = cfg_wdata[LIM_W-1:0];
                CFG_SEP_THR:   cfg_next.separation_threshold = cfg_wdata[LIM_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode                 <= MODE_POSITIONAL;
            cfg_reg.gain_p               <= '0;
            cfg_reg.gain_i               <= '0;
            cfg_reg.gain_d               <= '0;
            cfg_reg.output_limit         <= LIM_RESET;
            cfg_reg.integral_limit       <= LIM_RESET;
            cfg_reg.dead_zone            <= '0;
            cfg_reg.separation_threshold <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/pcpd_qmul.sv
// q16.16 gain times value, floor shift by 16 and saturation to 32 bits
module pcpd_qmul (
    input  logic signed [pcpd_pkg::DATA_W-1:0] gain,
    input  logic signed [pcpd_pkg::DATA_W-1:0] value,
    output logic signed [pcpd_pkg::DATA_W-1:0] product
);
    import pcpd_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int SHIFT  = 16;
    localparam int TOP_W  = PROD_W - SHIFT - DATA_W + 1;

    logic signed [PROD_W-1:0] full;
    logic [TOP_W-1:0]         top_bits;

    assign full     = PROD_W'(gain) * PROD_W'(value);
    assign top_bits = full[PROD_W-1:SHIFT+DATA_W-1];

    always_comb begin
        if ((&top_bits) || !(|top_bits)) begin
            product = full[SHIFT+DATA_W-1:SHIFT];
        end else if (full[PROD_W-1]) begin
            product = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            product = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

endmodule

>>> rtl/pcpd_calc.sv
// one pass of the controller: error, dead zone, three gain products, clamps, next state
module pcpd_calc (
    input  pcpd_pkg::cfg_t   cfg,
    input  pcpd_pkg::state_t state,
    input  pcpd_pkg::in_t    in_word,
    output pcpd_pkg::out_t   result,
    output pcpd_pkg::state_t state_next
);
    import pcpd_pkg::*;

    logic signed [DATA_W-1:0] err;
    logic [DATA_W-1:0]        mag;
    logic                     dead;
    logic                     skip_i;
    logic signed [DATA_W-1:0] d1;
    logic signed [DATA_W-1:0] d2;
    logic signed [DATA_W-1:0] op_p;
    logic signed [DATA_W-1:0] op_d;
    logic signed [DATA_W-1:0] q_p;
    logic signed [DATA_W-1:0] q_i;
    logic signed [DATA_W-1:0] q_d;
    logic signed [DATA_W-1:0] integ_new;
    logic signed [DATA_W-1:0] i_inc;
    logic signed [DATA_W-1:0] drive_pos;
    logic signed [DATA_W-1:0] drive_inc;
    logic signed [SUM_W-1:0]  i_used;

    assign err  = sat32(ext32(in_word.target) - ext32(in_word.measured));
    assign mag  = err[DATA_W-1] ? (~err + 1'b1) : err;
    assign dead = (|cfg.dead_zone) && (mag < {1'b0, cfg.dead_zone});
    assign skip_i = (|cfg.separation_threshold) && (mag > {1'b0, cfg.separation_threshold});

    assign d1 = sat32(ext32(err) - ext32(state.prev_error));
    assign d2 = sat32(ext32(err) - (ext32(state.prev_error) <<< 1)
                      + ext32(state.prev_prev_error));

    // positional uses e and e-e1, incremental uses e-e1 and e-2e1+e2
    assign op_p = (cfg.mode == MODE_INCREMENTAL) ? d1 : err;
    assign op_d = (cfg.mode == MODE_INCREMENTAL) ? d2 : d1;

    pcpd_qmul u_mul_p (.gain(cfg.gain_p), .value(op_p), .product(q_p));
    pcpd_qmul u_mul_i (.gain(cfg.gain_i), .value(err),  .product(q_i));
    pcpd_qmul u_mul_d (.gain(cfg.gain_d), .value(op_d), .product(q_d));

    assign integ_new = clamp_sym(ext32(state.integral_sum) + ext32(q_i), cfg.integral_limit);
    assign i_inc     = clamp_sym(ext32(q_i), cfg.integral_limit);
    assign i_used    = skip_i ? '0 : ext32(integ_new);
    assign drive_pos = clamp_sym(ext32(q_p) + ext32(q_d) + i_used, cfg.output_limit);
    assign drive_inc = clamp_sym(ext32(state.last_incremental_output) + ext32(q_p)
                                 + ext32(i_inc) + ext32(q_d), cfg.output_limit);

    always_comb begin
        state_next = state;
        result.in_dead_zone = dead;
        result.drive        = '0;
        if (!dead) begin
            state_next.prev_prev_error = state.prev_error;
            state_next.prev_error      = err;
            if (cfg.mode == MODE_INCREMENTAL) begin
                result.drive                       = drive_inc;
                state_next.last_incremental_output = drive_inc;
            end else begin
                result.drive            = drive_pos;
                state_next.integral_sum = integ_new;
            end
        end
    end

endmodule

>>> rtl/pid_controller_position_delta_core.sv
// top level of the positional / incremental pid core with input and result registers
// the input register feeds the combinational calculation; the result register drives m_data
// throughput: one word per cycle unless m_ready stalls, one pass through the gain multipliers
// a waiting result stalls the input only once the input register also holds a word
// reset (aresetn low, synchronous) clears valids, error history, integral and last output
module pid_controller_position_delta_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [pcpd_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [pcpd_pkg::DATA_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  pcpd_pkg::in_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output pcpd_pkg::out_t              m_data
);
    import pcpd_pkg::*;

    cfg_t   cfg;
    in_t    in_data_reg;
    logic   in_valid_reg;
    logic   in_valid_next;
    out_t   out_data_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    state_t state_reg;
    state_t state_calc;
    state_t state_next;
    out_t   result;
    logic   fire;
    logic   take;

    pcpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pcpd_calc u_calc (
        .cfg        (cfg),
        .state      (state_reg),
        .in_word    (in_data_reg),
        .result     (result),
        .state_next (state_calc)
    );

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign take    = s_valid && s_ready;

    always_comb begin
        in_valid_next  = take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
        state_next     = fire ? state_calc : state_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_dead_zone_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.in_dead_zone |-> m_data.drive == '0)
        else $error("dead zone word with nonzero drive");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a blocked result");

    a_dead_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.in_dead_zone |=> $stable(state_reg))
        else $error("state changed on a dead zone word");

    a_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result lost");

    a_idle_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(state_reg))
        else $error("state changed without a word");

endmodule
